// File: design/rag_pkg.sv
`default_nettype none

package rag_pkg;

	localparam int WORD_BITS = 32;
	localparam int IN_W = 32;
	localparam int OP_W = IN_W + 1;
	localparam int PROD_W = 2 * OP_W;
	localparam int GW = 64;
	localparam int CNT_W = $clog2(GW + 1);
	localparam int K_W = $clog2(GW);

	localparam logic [GW-1:0] LIM = GW'(1) << (WORD_BITS - 1);

	localparam logic [2:0] ACT_LOAD = 3'd0;
	localparam logic [2:0] ACT_ADD = 3'd1;
	localparam logic [2:0] ACT_INC = 3'd2;
	localparam logic [2:0] ACT_DEC = 3'd3;
	localparam logic [2:0] ACT_CMP = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic signed [IN_W-1:0] operand_num;
		logic signed [IN_W-1:0] operand_den;
	} item_t;

	typedef struct packed {
		logic signed [IN_W-1:0] acc_num;
		logic [IN_W-2:0] acc_den;
		logic is_equal;
		logic is_less;
		logic is_nonzero;
		logic [1:0] status;
	} result_t;

endpackage

`default_nettype wire

// File: design/rag_mul.sv
`default_nettype none

module rag_mul (
	input wire logic clk,
	input wire logic signed [rag_pkg::OP_W-1:0] x,
	input wire logic signed [rag_pkg::OP_W-1:0] y,
	output logic signed [rag_pkg::PROD_W-1:0] p
);

	logic signed [rag_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= rag_pkg::PROD_W'(x) * rag_pkg::PROD_W'(y);
	end

	assign p = p_q;

endmodule

`default_nettype wire

// File: design/rag_gcd.sv
`default_nettype none

module rag_gcd (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [rag_pkg::GW-1:0] a,
	input wire logic [rag_pkg::GW-1:0] b,
	output logic done,
	output logic [rag_pkg::GW-1:0] g
);

	logic busy_q;
	logic done_q;
	logic [rag_pkg::GW-1:0] u_q;
	logic [rag_pkg::GW-1:0] v_q;
	logic [rag_pkg::K_W-1:0] k_q;
	logic [rag_pkg::GW-1:0] g_q;

	// binary gcd: one shift or subtract per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (u_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= a;
			v_q <= b;
			k_q <= '0;
		end else if (busy_q) begin
			priority if (u_q == '0) begin
				g_q <= v_q << k_q;
			end else if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + rag_pkg::K_W'(1);
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
	end

	assign done = done_q;
	assign g = g_q;

endmodule

`default_nettype wire

// File: design/rag_div.sv
`default_nettype none

module rag_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [rag_pkg::GW-1:0] dividend,
	input wire logic [rag_pkg::GW-1:0] divisor,
	output logic done,
	output logic [rag_pkg::GW-1:0] quo
);

	logic busy_q;
	logic done_q;
	logic [rag_pkg::CNT_W-1:0] cnt_q;
	logic [rag_pkg::GW-1:0] rem_q;
	logic [rag_pkg::GW-1:0] quo_q;
	logic [rag_pkg::GW-1:0] dvs_q;
	logic [rag_pkg::GW:0] r_sh;
	logic [rag_pkg::GW:0] diff;
	logic ge;

	// restoring division, one quotient bit per cycle
	assign r_sh = {rem_q, quo_q[rag_pkg::GW-1]};
	assign diff = r_sh - {1'b0, dvs_q};
	assign ge = r_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= rag_pkg::CNT_W'(rag_pkg::GW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - rag_pkg::CNT_W'(1);
				if (cnt_q == rag_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[rag_pkg::GW-1:0];
			end else begin
				rem_q <= r_sh[rag_pkg::GW-1:0];
			end
			quo_q <= {quo_q[rag_pkg::GW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

`default_nettype wire

// File: design/rational_accumulator_gcd_reduce.sv
// path from the accepting edge to result_valid: unused actions and zero denominators go
// straight to the done step; compare runs the products in S_MUL_AD and S_MUL_CB, then S_CMP;
// load, add, increment and decrement run the binary gcd (one shift or subtract a cycle),
// two divisions skipped when the gcd is one, and the S_MUL_AD to S_SUM product steps on add paths
// throughput: one item in flight; the next transfer is taken once the sequencer is idle
// reset: accumulator 0/1, sequencer idle, no result pending; a stalled result holds the last step
`default_nettype none

module rational_accumulator_gcd_reduce (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire rag_pkg::item_t item,
	output logic result_valid,
	input wire logic result_stall,
	output rag_pkg::result_t result
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL_AD = 4'd1;
	localparam logic [3:0] S_MUL_CB = 4'd2;
	localparam logic [3:0] S_MUL_BD = 4'd3;
	localparam logic [3:0] S_SUM = 4'd4;
	localparam logic [3:0] S_CMP = 4'd5;
	localparam logic [3:0] S_PREP = 4'd6;
	localparam logic [3:0] S_GCD = 4'd7;
	localparam logic [3:0] S_DIV_MAG = 4'd8;
	localparam logic [3:0] S_DIV_DEN = 4'd9;
	localparam logic [3:0] S_CHECK = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	logic [3:0] state_q;
	logic [3:0] idle_next;
	logic result_valid_q;
	rag_pkg::result_t result_q;
	logic out_free;

	logic signed [rag_pkg::WORD_BITS-1:0] acc_num_q;
	logic [rag_pkg::WORD_BITS-2:0] acc_den_q;

	logic [2:0] action_q;
	logic signed [rag_pkg::OP_W-1:0] c_q;
	logic [rag_pkg::IN_W-1:0] d_q;
	logic signed [rag_pkg::GW-1:0] lhs_q;
	logic [rag_pkg::GW-1:0] num_q;
	logic [rag_pkg::GW-1:0] den_q;
	logic [rag_pkg::GW-1:0] mag_q;
	logic neg_q;
	logic [rag_pkg::GW-1:0] qm_q;
	logic [rag_pkg::GW-1:0] qd_q;
	logic [1:0] status_q;
	logic eq_q;
	logic lt_q;

	logic item_take;
	logic signed [rag_pkg::OP_W-1:0] c_raw;
	logic signed [rag_pkg::OP_W-1:0] d_raw;
	logic signed [rag_pkg::OP_W-1:0] c_fix;
	logic signed [rag_pkg::OP_W-1:0] d_fix;
	logic [rag_pkg::IN_W-1:0] d_mag;
	logic d_zero;

	logic signed [rag_pkg::OP_W-1:0] mul_x;
	logic signed [rag_pkg::OP_W-1:0] mul_y;
	logic signed [rag_pkg::PROD_W-1:0] mul_p;
	logic signed [rag_pkg::GW-1:0] prod;

	logic [rag_pkg::GW-1:0] mag_c;
	logic gcd_start;
	logic gcd_done;
	logic [rag_pkg::GW-1:0] gcd_g;
	logic g_one;

	logic div_start;
	logic div_done;
	logic [rag_pkg::GW-1:0] div_dividend;
	logic [rag_pkg::GW-1:0] div_quo;

	logic ovf;
	logic [rag_pkg::GW-1:0] num_res;

	assign item_stall = (state_q != S_IDLE);
	assign item_take = item_valid && !item_stall;
	assign out_free = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result = result_q;

	// operand decode, sign moved to the numerator
	always_comb begin
		unique case (item.action)
			rag_pkg::ACT_INC: begin
				c_raw = rag_pkg::OP_W'(1);
				d_raw = rag_pkg::OP_W'(1);
			end
			rag_pkg::ACT_DEC: begin
				c_raw = -rag_pkg::OP_W'(1);
				d_raw = rag_pkg::OP_W'(1);
			end
			default: begin
				c_raw = rag_pkg::OP_W'(item.operand_num);
				d_raw = rag_pkg::OP_W'(item.operand_den);
			end
		endcase
		c_fix = d_raw[rag_pkg::OP_W-1] ? -c_raw : c_raw;
		d_fix = d_raw[rag_pkg::OP_W-1] ? -d_raw : d_raw;
		d_mag = d_fix[rag_pkg::IN_W-1:0];
		d_zero = (d_mag == '0);
	end

	always_comb begin
		unique case (item.action)
			rag_pkg::ACT_LOAD: idle_next = d_zero ? S_DONE : S_PREP;
			rag_pkg::ACT_ADD, rag_pkg::ACT_INC, rag_pkg::ACT_DEC, rag_pkg::ACT_CMP:
				idle_next = d_zero ? S_DONE : S_MUL_AD;
			default: idle_next = S_DONE;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_MUL_AD: begin
				mul_x = rag_pkg::OP_W'(acc_num_q);
				mul_y = signed'({1'b0, d_q});
			end
			S_MUL_CB: begin
				mul_x = c_q;
				mul_y = signed'(rag_pkg::OP_W'(acc_den_q));
			end
			S_MUL_BD: begin
				mul_x = signed'(rag_pkg::OP_W'(acc_den_q));
				mul_y = signed'({1'b0, d_q});
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	rag_mul u_mul (
		.clk(clk),
		.x(mul_x),
		.y(mul_y),
		.p(mul_p)
	);

	assign prod = signed'(mul_p[rag_pkg::GW-1:0]);

	assign mag_c = num_q[rag_pkg::GW-1] ? (rag_pkg::GW'(0) - num_q) : num_q;
	assign gcd_start = (state_q == S_PREP);

	rag_gcd u_gcd (
		.clk(clk),
		.arst_n(arst_n),
		.start(gcd_start),
		.a(mag_c),
		.b(den_q),
		.done(gcd_done),
		.g(gcd_g)
	);

	assign g_one = (gcd_g == rag_pkg::GW'(1));
	assign div_start = ((state_q == S_GCD) && gcd_done && !g_one) ||
		((state_q == S_DIV_MAG) && div_done);
	assign div_dividend = (state_q == S_GCD) ? mag_q : den_q;

	rag_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(gcd_g),
		.done(div_done),
		.quo(div_quo)
	);

	assign ovf = (qd_q > rag_pkg::LIM - rag_pkg::GW'(1)) ||
		(neg_q ? (qm_q > rag_pkg::LIM) : (qm_q > rag_pkg::LIM - rag_pkg::GW'(1)));
	assign num_res = neg_q ? (rag_pkg::GW'(0) - qm_q) : qm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			result_valid_q <= 1'b0;
			acc_num_q <= '0;
			acc_den_q <= (rag_pkg::WORD_BITS-1)'(1);
		end else begin
			if (result_valid_q && !result_stall && (state_q != S_DONE)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_take) begin
						state_q <= idle_next;
					end
				end
				S_MUL_AD: state_q <= S_MUL_CB;
				S_MUL_CB: state_q <= (action_q == rag_pkg::ACT_CMP) ? S_CMP : S_MUL_BD;
				S_MUL_BD: state_q <= S_SUM;
				S_SUM: state_q <= S_PREP;
				S_CMP: state_q <= S_DONE;
				S_PREP: state_q <= S_GCD;
				S_GCD: begin
					if (gcd_done) begin
						state_q <= g_one ? S_CHECK : S_DIV_MAG;
					end
				end
				S_DIV_MAG: begin
					if (div_done) begin
						state_q <= S_DIV_DEN;
					end
				end
				S_DIV_DEN: begin
					if (div_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (!ovf) begin
						acc_num_q <= num_res[rag_pkg::WORD_BITS-1:0];
						acc_den_q <= qd_q[rag_pkg::WORD_BITS-2:0];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_take) begin
					action_q <= item.action;
					c_q <= c_fix;
					d_q <= d_mag;
					num_q <= rag_pkg::GW'(c_fix);
					den_q <= rag_pkg::GW'(d_mag);
					eq_q <= 1'b0;
					lt_q <= 1'b0;
					status_q <= (d_zero && (item.action <= rag_pkg::ACT_CMP)) ?
						rag_pkg::ST_ZERO_DEN : rag_pkg::ST_OK;
				end
			end
			S_MUL_CB: lhs_q <= prod;
			S_MUL_BD: num_q <= lhs_q + prod;
			S_SUM: den_q <= prod;
			S_CMP: begin
				eq_q <= (lhs_q == prod);
				lt_q <= (lhs_q < prod);
			end
			S_PREP: begin
				neg_q <= num_q[rag_pkg::GW-1];
				mag_q <= mag_c;
			end
			S_GCD: begin
				if (gcd_done && g_one) begin
					qm_q <= mag_q;
					qd_q <= den_q;
				end
			end
			S_DIV_MAG: begin
				if (div_done) begin
					qm_q <= div_quo;
				end
			end
			S_DIV_DEN: begin
				if (div_done) begin
					qd_q <= div_quo;
				end
			end
			S_CHECK: begin
				if (ovf) begin
					status_q <= rag_pkg::ST_OVERFLOW;
				end
			end
			S_DONE: begin
				if (out_free) begin
					result_q.acc_num <= rag_pkg::IN_W'(acc_num_q);
					result_q.acc_den <= (rag_pkg::IN_W-1)'(acc_den_q);
					result_q.is_equal <= eq_q;
					result_q.is_less <= lt_q;
					result_q.is_nonzero <= (acc_num_q != '0);
					result_q.status <= status_q;
				end
			end
			default: ;
		endcase
	end

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		acc_den_q != '0)
		else $error("accumulator denominator is zero");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the done step");

	a_gcd_done_in_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_done |-> state_q == S_GCD)
		else $error("gcd finished while the sequencer was elsewhere");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_MAG) || (state_q == S_DIV_DEN))
		else $error("divider finished while the sequencer was elsewhere");

	a_eq_lt_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> !(result_q.is_equal && result_q.is_less))
		else $error("equal and less reported together");

endmodule

`default_nettype wire
